/* rtl/cfr_pkg.sv */
package cfr_pkg;

  localparam int MaxDatagramDefault = 128;

  localparam logic [7:0] Sync0       = 8'hAA;
  localparam logic [7:0] Sync1       = 8'h55;
  localparam logic [7:0] ControlType = 8'h01;
  localparam int         MinFrame    = 7;
  localparam int         HdrBytes    = 5;
  localparam int         CtrlBytes   = 10;
  localparam int         PayIdxW     = $clog2(CtrlBytes);
  localparam int         LenCmpW     = 9;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [2:0] {
    StCtrlOk,
    StOtherOk,
    StShort,
    StSync,
    StLength,
    StCrc,
    StPayloadShort,
    StOversize
  } status_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/cfr_if.sv */
interface cfr_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfr_result_if import cfr_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [7:0] frame_type;
  logic [7:0] lamp_bits;
  logic [7:0] blinker;
  logic [7:0] strip_l_mode;
  logic [7:0] strip_l_color;
  logic [7:0] strip_r_mode;
  logic [7:0] strip_r_color;
  logic [7:0] strip_f_mode;
  logic [7:0] strip_f_color;
  logic       chg_en;
  logic       dischg_en;

  modport source (
    output valid, output status, output frame_type, output lamp_bits, output blinker,
    output strip_l_mode, output strip_l_color, output strip_r_mode, output strip_r_color,
    output strip_f_mode, output strip_f_color, output chg_en, output dischg_en,
    input ready
  );
  modport sink (
    input valid, input status, input frame_type, input lamp_bits, input blinker,
    input strip_l_mode, input strip_l_color, input strip_r_mode, input strip_r_color,
    input strip_f_mode, input strip_f_color, input chg_en, input dischg_en,
    output ready
  );
endinterface

/* rtl/control_frame_receiver_core.sv */
// Takes one datagram byte per cycle; the input is stalled only while a result is
// held in the output register and not taken.
// The result of a datagram is registered and appears in the cycle after its last byte is transferred.
// The CRC-16 update of one byte per cycle is the longest path.
// Synchronous active-high reset clears the frame state and the output valid; the
// payload holding registers are not reset.
module control_frame_receiver_core
  import cfr_pkg::*;
#(
  parameter int MAX_DATAGRAM = MaxDatagramDefault
) (
  input logic           clk,
  input logic           rst,
  cfr_byte_if.sink      rx,
  cfr_result_if.source  result
);

  localparam int CntW = $clog2(MAX_DATAGRAM + 2);

  logic [CntW-1:0]    cnt;
  logic [CntW-1:0]    cnt_next;
  logic               sync_ok;
  logic               sync_ok_next;
  logic [7:0]         type_hold;
  logic [7:0]         type_hold_next;
  logic [7:0]         length_hold;
  logic [7:0]         length_hold_next;
  logic [15:0]        crc_running;
  logic [15:0]        crc_running_next;
  logic [15:0]        tail_delay;
  logic [15:0]        tail_delay_next;
  logic [7:0]         payload_head [CtrlBytes];
  logic               pay_wr;
  logic [PayIdxW-1:0] pay_idx;
  logic [CntW-1:0]    pay_off;
  logic               accept;
  status_t            stat;
  logic [LenCmpW-1:0] n_ext;
  logic [LenCmpW-1:0] len_total;
  logic [15:0]        got;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = !result.valid || result.ready;
  assign pay_off  = cnt - CntW'(HdrBytes);
  assign pay_idx  = pay_off[PayIdxW-1:0];

  always_comb begin
    cnt_next         = cnt;
    sync_ok_next     = sync_ok;
    type_hold_next   = type_hold;
    length_hold_next = length_hold;
    crc_running_next = crc_running;
    tail_delay_next  = tail_delay;
    pay_wr           = 1'b0;
    if (cnt >= CntW'(MAX_DATAGRAM)) begin
      cnt_next = CntW'(MAX_DATAGRAM + 1);
    end else begin
      if (cnt == CntW'(0) && rx.data_byte != Sync0) begin
        sync_ok_next = 1'b0;
      end
      if (cnt == CntW'(1) && rx.data_byte != Sync1) begin
        sync_ok_next = 1'b0;
      end
      if (cnt == CntW'(3)) begin
        type_hold_next = rx.data_byte;
      end
      if (cnt == CntW'(4)) begin
        length_hold_next = rx.data_byte;
      end
      if (cnt >= CntW'(HdrBytes) && cnt < CntW'(HdrBytes + CtrlBytes)) begin
        pay_wr = 1'b1;
      end
      if (cnt >= CntW'(4)) begin
        crc_running_next = crc_feed(crc_running, tail_delay[15:8]);
      end
      tail_delay_next = {tail_delay[7:0], rx.data_byte};
      cnt_next        = cnt + CntW'(1);
    end
  end

  always_comb begin
    n_ext     = LenCmpW'(cnt_next);
    len_total = LenCmpW'(MinFrame) + LenCmpW'(length_hold_next);
    got       = {tail_delay_next[7:0], tail_delay_next[15:8]};
    if (cnt_next > CntW'(MAX_DATAGRAM)) begin
      stat = StOversize;
    end else if (cnt_next < CntW'(MinFrame)) begin
      stat = StShort;
    end else if (!sync_ok_next) begin
      stat = StSync;
    end else if (n_ext != len_total) begin
      stat = StLength;
    end else if (got != crc_running_next) begin
      stat = StCrc;
    end else if (type_hold_next != ControlType) begin
      stat = StOtherOk;
    end else if (length_hold_next < 8'(CtrlBytes)) begin
      stat = StPayloadShort;
    end else begin
      stat = StCtrlOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      sync_ok     <= 1'b1;
      type_hold   <= '0;
      length_hold <= '0;
      crc_running <= CrcInit;
      tail_delay  <= '0;
    end else if (accept) begin
      if (rx.last_byte) begin
        cnt         <= '0;
        sync_ok     <= 1'b1;
        type_hold   <= '0;
        length_hold <= '0;
        crc_running <= CrcInit;
        tail_delay  <= '0;
      end else begin
        cnt         <= cnt_next;
        sync_ok     <= sync_ok_next;
        type_hold   <= type_hold_next;
        length_hold <= length_hold_next;
        crc_running <= crc_running_next;
        tail_delay  <= tail_delay_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pay_wr) begin
      payload_head[pay_idx] <= rx.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && rx.last_byte) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx.last_byte) begin
      result.status     <= stat;
      result.frame_type <= (cnt_next >= CntW'(HdrBytes)) ? type_hold_next : 8'h00;
      if (stat == StCtrlOk) begin
        result.lamp_bits     <= payload_head[0];
        result.blinker       <= payload_head[1];
        result.strip_l_mode  <= payload_head[2];
        result.strip_l_color <= payload_head[3];
        result.strip_r_mode  <= payload_head[4];
        result.strip_r_color <= payload_head[5];
        result.strip_f_mode  <= payload_head[6];
        result.strip_f_color <= payload_head[7];
        result.chg_en        <= (payload_head[8] != 8'h00);
        result.dischg_en     <= (payload_head[9] != 8'h00);
      end else begin
        result.lamp_bits     <= '0;
        result.blinker       <= '0;
        result.strip_l_mode  <= '0;
        result.strip_l_color <= '0;
        result.strip_r_mode  <= '0;
        result.strip_r_color <= '0;
        result.strip_f_mode  <= '0;
        result.strip_f_color <= '0;
        result.chg_en        <= 1'b0;
        result.dischg_en     <= 1'b0;
      end
    end
  end

endmodule
